### src/bmprs_pkg.sv
// shared types and constants for the bmp24 to rgb565 row streamer
package bmprs_pkg;

    localparam logic [1:0] KIND_WINDOW = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [0:0] CFG_COL_OFFSET = 1'd0;
    localparam logic [0:0] CFG_ROW_OFFSET = 1'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  col_first;
        logic [7:0]  col_last;
        logic [7:0]  row;
        logic [15:0] color;
        logic        last_of_image;
    } res_t;

endpackage

### src/bmprs_parser.sv
// header parser, crop and row walker that turns one file byte into at most one result
module bmprs_parser #(
    parameter int unsigned SCREEN_WIDTH    = 128,
    parameter int unsigned SCREEN_HEIGHT   = 128,
    parameter int unsigned MAX_IMAGE_WIDTH = 1280
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_vld,
    input  logic [7:0]         in_byte,
    input  logic               in_sof,
    input  logic [7:0]         col_off,
    input  logic [7:0]         row_off,
    output logic               res_vld,
    output bmprs_pkg::res_t    res
);

    localparam int unsigned LBW = $clog2(3 * MAX_IMAGE_WIDTH + 4);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SEEK   = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_ROWS   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [2:0] CHK_ALL    = 3'b111;
    localparam logic [2:0] CHK_PLANES = 3'b001;
    localparam logic [2:0] CHK_DEPTH  = 3'b010;
    localparam logic [2:0] CHK_COMPR  = 3'b100;

    localparam logic [31:0] HDR_OFFSET      = 32'd10;
    localparam logic [31:0] HDR_WIDTH       = 32'd18;
    localparam logic [31:0] HDR_HEIGHT      = 32'd22;
    localparam logic [31:0] HDR_PLANES      = 32'd26;
    localparam logic [31:0] HDR_DEPTH       = 32'd28;
    localparam logic [31:0] HDR_COMPR       = 32'd30;
    localparam logic [31:0] HDR_END         = 32'd33;
    localparam logic [31:0] MIN_DATA_OFFSET = 32'd54;
    localparam logic [7:0]  BMP_DEPTH       = 8'd24;

    logic [31:0]    pos_reg, pos_next;
    logic [31:0]    doff_reg, doff_next;
    logic [31:0]    width_reg, width_next;
    logic [31:0]    height_reg, height_next;
    logic [2:0]     chk_reg, chk_next;
    logic [2:0]     phase_reg, phase_next;
    logic [31:0]    skip_reg, skip_next;
    logic [LBW-1:0] lbc_reg, lbc_next;
    logic [1:0]     pbi_reg, pbi_next;
    logic [15:0]    pc_reg, pc_next;
    logic [7:0]     crow_reg, crow_next;

    // geometry latched at the end of the header
    logic [LBW-1:0] iw_reg, w3_reg;
    logic [7:0]     xs_reg, wm1_reg, frow_reg;

    logic           wide, tall, hdr_ok, load_geom;
    logic [31:0]    shown32, frow32;
    logic [LBW-1:0] iw_calc, w3_calc;
    logic [7:0]     xs_calc, wm1_calc, frow_calc, crow_calc;
    logic [31:0]    skip_calc;

    logic [31:0]    idx;
    logic [1:0]     sel;
    logic           run_data, go, stop, last;

    always_comb begin
        wide      = width_reg > SCREEN_WIDTH;
        tall      = height_reg > SCREEN_HEIGHT;
        shown32   = wide ? SCREEN_WIDTH : width_reg;
        iw_calc   = LBW'((width_reg * 32'd3 + 32'd3) & ~32'd3);
        w3_calc   = LBW'(shown32 * 32'd3);
        wm1_calc  = 8'(shown32 - 32'd1);
        xs_calc   = wide ? 8'd0 : 8'((SCREEN_WIDTH - width_reg) >> 1);
        frow32    = tall ? 32'd0 : ((SCREEN_HEIGHT - height_reg) >> 1);
        frow_calc = 8'(frow32);
        crow_calc = tall ? 8'(SCREEN_HEIGHT - 1) : 8'(frow32 + height_reg - 32'd1);
        skip_calc = tall ? (height_reg - SCREEN_HEIGHT) : 32'd0;
    end

    always_comb begin
        pos_next    = pos_reg;
        doff_next   = doff_reg;
        width_next  = width_reg;
        height_next = height_reg;
        chk_next    = chk_reg;
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        lbc_next    = lbc_reg;
        pbi_next    = pbi_reg;
        pc_next     = pc_reg;
        crow_next   = crow_reg;
        res_vld     = 1'b0;
        res         = '0;
        idx         = '0;
        sel         = '0;
        run_data    = 1'b0;
        go          = 1'b0;
        stop        = 1'b0;
        last        = 1'b0;
        hdr_ok      = 1'b0;
        load_geom   = 1'b0;

        if (in_vld) begin
            if (in_sof) begin
                pos_next    = '0;
                doff_next   = '0;
                width_next  = '0;
                height_next = '0;
                chk_next    = CHK_ALL;
                skip_next   = '0;
                lbc_next    = '0;
                pbi_next    = '0;
                pc_next     = '0;
                crow_next   = '0;
                phase_next  = PH_HEADER;
            end
            if (phase_next != PH_IDLE && phase_next != PH_DONE) begin
                idx = pos_next;
                if (pos_next != '1) begin
                    pos_next = pos_next + 32'd1;
                end
                case (phase_next)
                    PH_HEADER: begin
                        if (idx >= HDR_OFFSET && idx <= HDR_OFFSET + 32'd3) begin
                            sel = 2'(idx - HDR_OFFSET);
                            doff_next[sel*8 +: 8] = in_byte;
                        end
                        if (idx >= HDR_WIDTH && idx <= HDR_WIDTH + 32'd3) begin
                            sel = 2'(idx - HDR_WIDTH);
                            width_next[sel*8 +: 8] = in_byte;
                        end
                        if (idx >= HDR_HEIGHT && idx <= HDR_HEIGHT + 32'd3) begin
                            sel = 2'(idx - HDR_HEIGHT);
                            height_next[sel*8 +: 8] = in_byte;
                        end
                        if ((idx == HDR_PLANES && in_byte != 8'd1) ||
                            (idx == HDR_PLANES + 32'd1 && in_byte != 8'd0)) begin
                            chk_next = chk_next & ~CHK_PLANES;
                        end
                        if ((idx == HDR_DEPTH && in_byte != BMP_DEPTH) ||
                            (idx == HDR_DEPTH + 32'd1 && in_byte != 8'd0)) begin
                            chk_next = chk_next & ~CHK_DEPTH;
                        end
                        if (idx >= HDR_COMPR && idx <= HDR_COMPR + 32'd3 && in_byte != 8'd0) begin
                            chk_next = chk_next & ~CHK_COMPR;
                        end
                        if (idx == HDR_END) begin
                            hdr_ok = chk_next == CHK_ALL && width_next != 32'd0 &&
                                     width_next <= MAX_IMAGE_WIDTH && height_next != 32'd0 &&
                                     doff_next >= MIN_DATA_OFFSET;
                            if (!hdr_ok) begin
                                phase_next = PH_DONE;
                                res_vld    = 1'b1;
                                res.kind   = bmprs_pkg::KIND_REJECT;
                            end else begin
                                load_geom  = 1'b1;
                                skip_next  = skip_calc;
                                crow_next  = crow_calc;
                                phase_next = PH_SEEK;
                            end
                        end
                    end
                    PH_SEEK: begin
                        if (idx == doff_next) begin
                            phase_next = PH_SKIP;
                            lbc_next   = '0;
                            pbi_next   = '0;
                            run_data   = 1'b1;
                        end
                    end
                    PH_SKIP, PH_ROWS: begin
                        run_data = 1'b1;
                    end
                    default: begin
                    end
                endcase

                if (run_data) begin
                    go = 1'b1;
                    if (phase_next == PH_SKIP) begin
                        if (skip_next == 32'd0) begin
                            phase_next = PH_ROWS;
                        end else begin
                            go       = 1'b0;
                            lbc_next = lbc_next + LBW'(1);
                            if (lbc_next >= iw_reg) begin
                                lbc_next  = '0;
                                skip_next = skip_next - 32'd1;
                                if (skip_next == 32'd0) begin
                                    phase_next = PH_ROWS;
                                end
                            end
                        end
                    end
                    if (go) begin
                        if (lbc_next == '0) begin
                            res_vld       = 1'b1;
                            res.kind      = bmprs_pkg::KIND_WINDOW;
                            res.col_first = col_off + xs_reg;
                            res.col_last  = col_off + xs_reg + wm1_reg;
                            res.row       = row_off + crow_next;
                            pbi_next      = '0;
                            pc_next       = '0;
                        end
                        if (lbc_next < w3_reg) begin
                            case (pbi_next)
                                2'd0: begin
                                    pc_next  = {11'd0, in_byte[7:3]};
                                    pbi_next = 2'd1;
                                end
                                2'd1: begin
                                    pc_next  = pc_next | {5'd0, in_byte[7:2], 5'd0};
                                    pbi_next = 2'd2;
                                end
                                default: begin
                                    last = crow_next <= frow_reg &&
                                           lbc_next == w3_reg - LBW'(1);
                                    pc_next           = pc_next | {in_byte[7:3], 11'd0};
                                    pbi_next          = 2'd0;
                                    res_vld           = 1'b1;
                                    res.kind          = bmprs_pkg::KIND_PIXEL;
                                    res.color         = pc_next;
                                    res.last_of_image = last;
                                    if (last) begin
                                        phase_next = PH_DONE;
                                        stop       = 1'b1;
                                    end
                                end
                            endcase
                        end
                        if (!stop) begin
                            lbc_next = lbc_next + LBW'(1);
                            if (lbc_next >= iw_reg) begin
                                lbc_next = '0;
                                if (crow_next != 8'd0) begin
                                    crow_next = crow_next - 8'd1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            doff_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            chk_reg    <= CHK_ALL;
            phase_reg  <= PH_IDLE;
            skip_reg   <= '0;
            lbc_reg    <= '0;
            pbi_reg    <= '0;
            pc_reg     <= '0;
            crow_reg   <= '0;
        end else begin
            pos_reg    <= pos_next;
            doff_reg   <= doff_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            chk_reg    <= chk_next;
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            lbc_reg    <= lbc_next;
            pbi_reg    <= pbi_next;
            pc_reg     <= pc_next;
            crow_reg   <= crow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_geom) begin
            iw_reg   <= iw_calc;
            w3_reg   <= w3_calc;
            xs_reg   <= xs_calc;
            wm1_reg  <= wm1_calc;
            frow_reg <= frow_calc;
        end
    end

endmodule

### src/bmp24_to_rgb565_row_streamer.sv
// top level: config registers, byte parser and registered output with skid stage
// result beats are registered; a beat that meets a stall passes through the skid entry first
// throughput: one file byte per cycle while s_tready is high; each gives at most one result beat
// a result that arrives during a stall waits in one skid entry; s_tready is low while it is full
// reset: offsets cleared, parser idle and ignoring bytes until a beat with start flag
module bmp24_to_rgb565_row_streamer #(
    parameter int unsigned SCREEN_WIDTH    = 128,
    parameter int unsigned SCREEN_HEIGHT   = 128,
    parameter int unsigned MAX_IMAGE_WIDTH = 1280
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // file_byte
    input  logic [0:0]  s_tuser,   // start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // col_first, col_last, row, color
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last_of_image
);

    logic [7:0]      col_off_reg, row_off_reg;
    logic            accept, take;
    logic            res_vld;
    bmprs_pkg::res_t res;
    logic            out_vld_reg, skid_vld_reg;
    bmprs_pkg::res_t out_reg, skid_reg;

    assign s_tready = !skid_vld_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_vld_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_off_reg <= '0;
            row_off_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                bmprs_pkg::CFG_COL_OFFSET: col_off_reg <= cfg_wdata;
                bmprs_pkg::CFG_ROW_OFFSET: row_off_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bmprs_parser #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (accept),
        .in_byte (s_tdata),
        .in_sof  (s_tuser[0]),
        .col_off (col_off_reg),
        .row_off (row_off_reg),
        .res_vld (res_vld),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (!out_vld_reg || take) begin
                if (skid_vld_reg) begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end else begin
                    out_vld_reg <= res_vld;
                end
            end else if (res_vld) begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || take) begin
            out_reg <= skid_vld_reg ? skid_reg : res;
        end else if (res_vld) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.color, out_reg.row, out_reg.col_last, out_reg.col_first};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_of_image;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held while output register empty");

    a_result_from_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        res_vld |-> accept)
        else $error("result produced without an accepted beat");

    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == bmprs_pkg::KIND_PIXEL))
        else $error("last flag on a beat that is not a pixel");

    a_pixel_no_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == bmprs_pkg::KIND_PIXEL) |-> (m_tdata[23:0] == 24'd0))
        else $error("window fields set on a pixel beat");

endmodule

### tb/tb_top.sv
// self-checking testbench for the bmp24 to rgb565 row streamer
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCR_W = 128;
    localparam int SCR_H = 128;
    localparam int MAX_W = 1280;

    // little-endian header field positions
    localparam int OFS_POS      = 10;
    localparam int WID_POS      = 18;
    localparam int HGT_POS      = 22;
    localparam int PLN_POS      = 26;
    localparam int BPP_POS      = 28;
    localparam int CMP_POS      = 30;
    localparam int HDR_LAST     = 33;
    localparam int MIN_DATA_OFS = 54;

    // header cut right after the last checked byte
    localparam int HDR_ONLY = -2;

    localparam logic [2:0] PS_IDLE   = 3'd0;
    localparam logic [2:0] PS_HEADER = 3'd1;
    localparam logic [2:0] PS_SEEK   = 3'd2;
    localparam logic [2:0] PS_SKIP   = 3'd3;
    localparam logic [2:0] PS_ROWS   = 3'd4;
    localparam logic [2:0] PS_DONE   = 3'd5;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } file_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_addr  = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;   // col_first, col_last, row, color
    logic [1:0]  m_tuser;   // kind
    logic        m_tlast;   // last_of_image

    file_beat_t       file_stream[$];
    bmprs_pkg::res_t  screen_writes[$];
    int               mismatches   = 0;
    int               fed_bytes    = 0;
    int               src_idle_pct = 0;
    int               snk_idle_pct = 0;
    bit               in_taken     = 1'b0;

    // decoder shadow state
    logic [7:0]   shift_col  = '0;
    logic [7:0]   shift_row  = '0;
    logic [31:0]  fpos       = '0;
    logic [31:0]  hdr_offset = '0;
    logic [31:0]  img_w      = '0;
    logic [31:0]  img_h      = '0;
    logic [2:0]   hdr_flags  = 3'b111;
    logic [2:0]   pstate     = PS_IDLE;
    logic [31:0]  skip_left  = '0;
    logic [31:0]  line_cnt   = '0;
    logic [1:0]   byte_sel   = '0;
    logic [15:0]  pix_acc    = '0;
    logic [31:0]  scr_row    = '0;

    bmp24_to_rgb565_row_streamer #(
        .SCREEN_WIDTH    (SCR_W),
        .SCREEN_HEIGHT   (SCR_H),
        .MAX_IMAGE_WIDTH (MAX_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    task automatic log_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic decode_header(input logic [31:0] idx, input logic [7:0] b);
        bmprs_pkg::res_t r;
        if (idx >= OFS_POS && idx <= OFS_POS + 3) hdr_offset[8*(idx-OFS_POS) +: 8] = b;
        if (idx >= WID_POS && idx <= WID_POS + 3) img_w[8*(idx-WID_POS) +: 8] = b;
        if (idx >= HGT_POS && idx <= HGT_POS + 3) img_h[8*(idx-HGT_POS) +: 8] = b;
        if ((idx == PLN_POS && b != 8'd1) || (idx == PLN_POS + 1 && b != 8'd0)) hdr_flags[0] = 1'b0;
        if ((idx == BPP_POS && b != 8'd24) || (idx == BPP_POS + 1 && b != 8'd0)) hdr_flags[1] = 1'b0;
        if (idx >= CMP_POS && idx <= HDR_LAST && b != 8'd0) hdr_flags[2] = 1'b0;
        if (idx != HDR_LAST) return;
        if (hdr_flags != 3'b111 || img_w == 0 || img_w > MAX_W || img_h == 0 ||
            hdr_offset < MIN_DATA_OFS) begin
            pstate = PS_DONE;
            r = '0;
            r.kind = bmprs_pkg::KIND_REJECT;
            screen_writes.push_back(r);
            return;
        end
        skip_left = (img_h > SCR_H) ? img_h - SCR_H : 32'd0;
        scr_row   = (img_h > SCR_H) ? SCR_H - 1 : (SCR_H - img_h) / 2 + img_h - 1;
        pstate    = PS_SEEK;
    endtask

    task automatic decode_pixel(input logic [7:0] b);
        logic [31:0]     lb;
        logic [31:0]     sw;
        logic [31:0]     xs;
        logic [31:0]     fr;
        logic            last;
        bmprs_pkg::res_t r;
        lb = ((img_w * 3) + 3) & ~32'd3;
        sw = (img_w > SCR_W) ? SCR_W : img_w;
        xs = (img_w > SCR_W) ? 32'd0 : (SCR_W - img_w) / 2;
        fr = (img_h > SCR_H) ? 32'd0 : (SCR_H - img_h) / 2;
        // cropped rows at the bottom of the file
        if (pstate == PS_SKIP) begin
            if (skip_left == 0) begin
                pstate = PS_ROWS;
            end else begin
                line_cnt++;
                if (line_cnt >= lb) begin
                    line_cnt = 0;
                    skip_left--;
                    if (skip_left == 0) pstate = PS_ROWS;
                end
                return;
            end
        end
        if (line_cnt == 0) begin
            r = '0;
            r.kind      = bmprs_pkg::KIND_WINDOW;
            r.col_first = 8'(shift_col + xs);
            r.col_last  = 8'(shift_col + xs + sw - 1);
            r.row       = 8'(shift_row + scr_row);
            screen_writes.push_back(r);
            byte_sel = 0;
            pix_acc  = '0;
        end
        if (line_cnt < 3 * sw) begin
            case (byte_sel)
                2'd0: begin
                    pix_acc  = {11'd0, b[7:3]};
                    byte_sel = 2'd1;
                end
                2'd1: begin
                    pix_acc  = pix_acc | ({10'd0, b[7:2]} << 5);
                    byte_sel = 2'd2;
                end
                default: begin
                    last     = (scr_row <= fr) && (line_cnt == 3 * sw - 1);
                    pix_acc  = pix_acc | ({11'd0, b[7:3]} << 11);
                    byte_sel = 2'd0;
                    r = '0;
                    r.kind          = bmprs_pkg::KIND_PIXEL;
                    r.color         = pix_acc;
                    r.last_of_image = last;
                    screen_writes.push_back(r);
                    if (last) begin
                        pstate = PS_DONE;
                        return;
                    end
                end
            endcase
        end
        line_cnt++;
        if (line_cnt >= lb) begin
            line_cnt = 0;
            if (scr_row > 0) scr_row--;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sof);
        logic [31:0] idx;
        if (sof) begin
            fpos       = '0;
            hdr_offset = '0;
            img_w      = '0;
            img_h      = '0;
            hdr_flags  = 3'b111;
            skip_left  = '0;
            line_cnt   = '0;
            byte_sel   = '0;
            pix_acc    = '0;
            scr_row    = '0;
            pstate     = PS_HEADER;
        end
        if (pstate == PS_IDLE || pstate == PS_DONE) return;
        idx = fpos;
        if (fpos != '1) fpos++;
        case (pstate)
            PS_HEADER: decode_header(idx, b);
            PS_SEEK: begin
                if (idx == hdr_offset) begin
                    pstate   = PS_SKIP;
                    line_cnt = '0;
                    byte_sel = '0;
                    decode_pixel(b);
                end
            end
            default: decode_pixel(b);
        endcase
    endtask

    task automatic check_write;
        bmprs_pkg::res_t want;
        if (screen_writes.size() == 0) begin
            log_mismatch($sformatf("beat with nothing expected, kind %0d", m_tuser));
            return;
        end
        want = screen_writes.pop_front();
        if (m_tuser !== want.kind)
            log_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
        if (m_tdata[7:0] !== want.col_first)
            log_mismatch($sformatf("col_first %0d, expected %0d", m_tdata[7:0], want.col_first));
        if (m_tdata[15:8] !== want.col_last)
            log_mismatch($sformatf("col_last %0d, expected %0d", m_tdata[15:8], want.col_last));
        if (m_tdata[23:16] !== want.row)
            log_mismatch($sformatf("row %0d, expected %0d", m_tdata[23:16], want.row));
        if (m_tdata[39:24] !== want.color)
            log_mismatch($sformatf("color %h, expected %h", m_tdata[39:24], want.color));
        if (m_tlast !== want.last_of_image)
            log_mismatch($sformatf("last_of_image %b, expected %b", m_tlast,
                                   want.last_of_image));
    endtask

    // monitor: predict on input beats, check output beats
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) decode_byte(s_tdata, s_tuser[0]);
        if (aresetn && m_tvalid && m_tready) check_write();
    end

    // driver
    always @(negedge aclk) begin
        file_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (file_stream.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = file_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.sof;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == bmprs_pkg::CFG_COL_OFFSET) shift_col = val;
        else shift_row = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained;
        while (file_stream.size() != 0 || s_tvalid || screen_writes.size() != 0)
            @(posedge aclk);
        // bytes that give no result may still be in the pipe
        repeat (4) @(posedge aclk);
    endtask

    task automatic queue_file(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] dofs, input logic [15:0] planes,
                              input logic [15:0] depth, input logic [31:0] comp,
                              input int data_len, input int fill);
        int         hdr_len;
        int         body;
        logic [7:0] v;
        file_beat_t fb;
        if (data_len == HDR_ONLY) begin
            hdr_len = HDR_LAST + 1;
            body    = 0;
        end else begin
            hdr_len = (dofs < HDR_LAST + 1) ? HDR_LAST + 1 : int'(dofs);
            body    = (data_len >= 0) ? data_len : int'((((w * 3) + 3) & ~32'd3) * h);
        end
        for (int i = 0; i < hdr_len + body; i++) begin
            v = 8'($urandom);
            if (i >= OFS_POS && i <= OFS_POS + 3) v = dofs[8*(i-OFS_POS) +: 8];
            else if (i >= WID_POS && i <= WID_POS + 3) v = w[8*(i-WID_POS) +: 8];
            else if (i >= HGT_POS && i <= HGT_POS + 3) v = h[8*(i-HGT_POS) +: 8];
            else if (i >= PLN_POS && i <= PLN_POS + 1) v = planes[8*(i-PLN_POS) +: 8];
            else if (i >= BPP_POS && i <= BPP_POS + 1) v = depth[8*(i-BPP_POS) +: 8];
            else if (i >= CMP_POS && i <= HDR_LAST) v = comp[8*(i-CMP_POS) +: 8];
            else if (i >= hdr_len && fill >= 0) v = fill[7:0];
            fb.data = v;
            fb.sof  = (i == 0);
            file_stream.push_back(fb);
        end
        fed_bytes += hdr_len + body;
    endtask

    task automatic queue_image(input logic [31:0] w, input logic [31:0] h,
                               input logic [31:0] dofs);
        queue_file(w, h, dofs, 16'd1, 16'd24, 32'd0, -1, -1);
    endtask

    task automatic queue_noise(input int n, input int sof_pct);
        file_beat_t fb;
        for (int i = 0; i < n; i++) begin
            fb.data = 8'($urandom);
            fb.sof  = ($urandom_range(0, 99) < sof_pct);
            file_stream.push_back(fb);
        end
        fed_bytes += n;
    endtask

    task automatic queue_random_files(input int budget);
        int          stop;
        int          sel;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] lb;
        stop = fed_bytes + budget;
        while (fed_bytes < stop) begin
            sel = $urandom_range(0, 39);
            w   = $urandom_range(1, 8);
            h   = $urandom_range(1, 5);
            lb  = ((w * 3) + 3) & ~32'd3;
            if (sel < 3) begin
                // header with some fields that may be broken
                queue_file(($urandom_range(0, 2) == 0) ? $urandom_range(0, 1400) : w,
                           ($urandom_range(0, 3) == 0) ? $urandom : h,
                           $urandom_range(48, 60),
                           ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd1,
                           ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd24,
                           ($urandom_range(0, 2) == 0) ? (32'd1 << (8 * $urandom_range(0, 3)))
                                                       : 32'd0,
                           $urandom_range(0, 8), -1);
            end else if (sel < 6) begin
                // truncated file
                queue_file(w, h, MIN_DATA_OFS + $urandom_range(0, 4), 16'd1, 16'd24, 32'd0,
                           $urandom_range(0, lb * h - 1), -1);
            end else if (sel < 8) begin
                queue_noise($urandom_range(5, 20), 10);
            end else begin
                queue_image(w, h, MIN_DATA_OFS + $urandom_range(0, 4));
                if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 3), 0);
            end
        end
    endtask

    initial begin
        src_idle_pct = 25;
        snk_idle_pct = 51;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_reg(bmprs_pkg::CFG_COL_OFFSET, 8'd0);
        write_reg(bmprs_pkg::CFG_ROW_OFFSET, 8'd0);

        // bytes before any start flag are dropped
        queue_noise(4, 0);
        queue_file(4, 1, 60, 16'd1, 16'd24, 32'd0, -1, 8'hFF);
        // wide image loses its right columns
        queue_file(130, 1, MIN_DATA_OFS, 16'd1, 16'd24, 32'd0, 12, -1);
        // tall image loses its bottom rows
        queue_file(1, 130, MIN_DATA_OFS, 16'd1, 16'd24, 32'd0, 12, -1);
        // top-down height reads as huge, so rows are skipped for good
        queue_file(2, 32'hFFFF_FFFF, MIN_DATA_OFS, 16'd1, 16'd24, 32'd0, 8, -1);
        // restart in mid-image
        queue_file(3, 3, MIN_DATA_OFS, 16'd1, 16'd24, 32'd0, 10, -1);
        queue_image(3, 2, MIN_DATA_OFS);
        // rejected headers
        queue_file(2, 2, MIN_DATA_OFS, 16'h0101, 16'd24, 32'd0, HDR_ONLY, -1);
        queue_file(2, 2, MIN_DATA_OFS, 16'd1, 16'h0118, 32'd0, HDR_ONLY, -1);
        queue_file(2, 2, MIN_DATA_OFS, 16'd1, 16'd24, 32'h0100_0000, HDR_ONLY, -1);
        queue_file(0, 2, MIN_DATA_OFS, 16'd1, 16'd24, 32'd0, HDR_ONLY, -1);
        queue_file(MAX_W + 1, 2, MIN_DATA_OFS, 16'd1, 16'd24, 32'd0, HDR_ONLY, -1);
        queue_file(2, 0, MIN_DATA_OFS, 16'd1, 16'd24, 32'd0, HDR_ONLY, -1);
        queue_file(2, 2, MIN_DATA_OFS - 1, 16'd1, 16'd24, 32'd0, HDR_ONLY, -1);
        wait_drained();

        src_idle_pct = 51;
        snk_idle_pct = 25;
        write_reg(bmprs_pkg::CFG_COL_OFFSET, 8'd255);
        write_reg(bmprs_pkg::CFG_ROW_OFFSET, 8'd255);
        queue_random_files(50);
        // sender holds off until the output side has caught up
        wait_drained();
        queue_random_files(30);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(bmprs_pkg::CFG_COL_OFFSET, 8'($urandom_range(0, 255)));
        write_reg(bmprs_pkg::CFG_ROW_OFFSET, 8'($urandom_range(0, 255)));
        queue_random_files(60);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
